// ----- design/ulss_pkg.sv -----
// Shared types and constants for the UV lamp sterilize sequencer.
// No dependencies; the sequencer top level and the register file import this package.
package ulss_pkg;

    // Default register values (tick = 100 ms)
    localparam int unsigned TICKS_PER_MIN = 600;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOUR_PER_DAY  = 24;

    localparam logic [19:0] DAY_LENGTH_RESET   = 20'(TICKS_PER_MIN * MIN_PER_HOUR * HOUR_PER_DAY);
    localparam logic [15:0] STERILIZE_RESET    = 16'(TICKS_PER_MIN * MIN_PER_HOUR);
    localparam logic [7:0]  DAILY_LIMIT_RESET  = 8'd2;
    localparam logic [7:0]  MAKING_LIMIT_RESET = 8'd7;
    localparam logic [19:0] MAKING_MAX_RESET   = 20'(TICKS_PER_MIN * 30);

    // Retry off hold length in ticks
    localparam logic [4:0] RETRY_HOLD_TICKS = 5'd30;

    // APB address width: five registers on a 4-byte stride
    localparam int unsigned ADDR_W = 5;

    // Register indexes (paddr[4:2])
    typedef enum logic [2:0] {
        REG_DAY_LENGTH   = 3'd0,
        REG_STERILIZE    = 3'd1,
        REG_DAILY_LIMIT  = 3'd2,
        REG_MAKING_LIMIT = 3'd3,
        REG_MAKING_MAX   = 3'd4
    } t_reg_idx;

    // Configuration register bundle
    typedef struct packed {
        logic [19:0] day_length_ticks;
        logic [15:0] sterilize_ticks;
        logic [7:0]  daily_sterilize_limit;
        logic [7:0]  making_count_limit;
        logic [19:0] making_max_ticks;
    } t_cfg;

endpackage

// ----- design/ulss_in_if.sv -----
// Input request channel: valid/ready handshake and one tick of sensor flags.
// No dependencies.
interface ulss_in_if;
    logic valid;
    logic ready;
    logic self_test;
    logic uv_allowed;
    logic ice_full;
    logic tray_at_throw;
    logic making_phase;
    logic cover_closed;
    logic extract_active;
    logic outlet_motor_moving;
    logic retry_request;
    logic companion_on;
    logic lamp_error;

    modport source (
        output valid, self_test, uv_allowed, ice_full, tray_at_throw, making_phase,
               cover_closed, extract_active, outlet_motor_moving, retry_request,
               companion_on, lamp_error,
        input  ready
    );
    modport sink (
        input  valid, self_test, uv_allowed, ice_full, tray_at_throw, making_phase,
               cover_closed, extract_active, outlet_motor_moving, retry_request,
               companion_on, lamp_error,
        output ready
    );
endinterface

// ----- design/ulss_out_if.sv -----
// Result request channel: valid/ready handshake and the lamp decision.
// No dependencies.
interface ulss_out_if;
    logic valid;
    logic ready;
    logic lamp_on;
    logic tray_uv_request;
    logic forced_off;

    modport source (
        output valid, lamp_on, tray_uv_request, forced_off,
        input  ready
    );
    modport sink (
        input  valid, lamp_on, tray_uv_request, forced_off,
        output ready
    );
endinterface

// ----- design/uv_lamp_sterilize_sequencer.sv -----
// UV lamp sterilize sequencer top level. A result is valid the cycle after
// its tick request is accepted. One tick per cycle unless the output stalls;
// input ready is high whenever the result register is empty or being taken.
// Reset (synchronous, active low) clears all sequencer state to standby with
// the lamp off and loads the register defaults.
// Depends on ulss_pkg, ulss_in_if, ulss_out_if and ulss_cfg_regs.
module uv_lamp_sterilize_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ulss_in_if.sink                     i_in,
    ulss_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ulss_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ulss_pkg::*;

    t_cfg w_cfg;

    ulss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer state
    logic [19:0] r_day_ticks,       n_day_ticks;
    logic [7:0]  r_sterilize_count, n_sterilize_count;
    logic [7:0]  r_making_count,    n_making_count;
    logic        r_seq_step,        n_seq_step;
    logic        r_run_active,      n_run_active;
    logic [15:0] r_run_ticks,       n_run_ticks;
    logic        r_full_seen,       n_full_seen;
    logic        r_arm_first,       n_arm_first;
    logic        r_arm_second,      n_arm_second;
    logic        r_phase_seen,      n_phase_seen;
    logic        r_making_enable,   n_making_enable;
    logic [19:0] r_making_ticks,    n_making_ticks;
    logic        r_cover_off_prev,  n_cover_off_prev;
    logic        r_extract_off,     n_extract_off;
    logic        r_retry_pending,   n_retry_pending;
    logic [4:0]  r_retry_ticks,     n_retry_ticks;
    logic        r_lamp_last,       n_lamp_last;

    // Result register
    logic r_out_valid;
    logic r_lamp_on,   n_lamp_on;
    logic r_tray_req,  n_tray_req;
    logic r_forced,    n_forced;

    // Working values
    logic        w_accept;
    logic        w_paused;
    logic        w_go;
    logic        w_retry_off;
    logic [20:0] w_day_inc;
    logic [7:0]  w_ster_cnt;
    logic [7:0]  w_make_cnt;
    logic [8:0]  w_ster_inc;
    logic [8:0]  w_make_inc;
    logic [20:0] w_make_ticks_inc;
    logic [16:0] w_run_inc;
    logic [4:0]  w_retry_inc;

    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_paused   = r_cover_off_prev | r_extract_off;

    assign w_day_inc        = {1'b0, r_day_ticks} + 21'd1;
    assign w_ster_inc       = {1'b0, w_ster_cnt} + 9'd1;
    assign w_make_inc       = {1'b0, w_make_cnt} + 9'd1;
    assign w_make_ticks_inc = {1'b0, r_making_ticks} + 21'd1;
    assign w_run_inc        = {1'b0, r_run_ticks} + 17'd1;
    assign w_retry_inc      = r_retry_ticks + 5'd1;

    // Next state and result for one tick
    always_comb begin
        n_day_ticks       = r_day_ticks;
        n_sterilize_count = r_sterilize_count;
        n_making_count    = r_making_count;
        n_seq_step        = r_seq_step;
        n_run_active      = r_run_active;
        n_run_ticks       = r_run_ticks;
        n_full_seen       = r_full_seen;
        n_arm_first       = r_arm_first;
        n_arm_second      = r_arm_second;
        n_phase_seen      = r_phase_seen;
        n_making_enable   = r_making_enable;
        n_making_ticks    = r_making_ticks;
        n_cover_off_prev  = r_cover_off_prev;
        n_extract_off     = r_extract_off;
        n_retry_pending   = r_retry_pending;
        n_retry_ticks     = r_retry_ticks;
        n_lamp_last       = r_lamp_last;
        n_tray_req        = 1'b0;
        n_forced          = 1'b0;
        n_lamp_on         = r_lamp_last;
        w_go              = 1'b0;
        w_retry_off       = 1'b0;

        // Day rollover clears the daily counts before they are used
        if (w_day_inc >= {1'b0, w_cfg.day_length_ticks}) begin
            w_ster_cnt = 8'd0;
            w_make_cnt = 8'd0;
        end else begin
            w_ster_cnt = r_sterilize_count;
            w_make_cnt = r_making_count;
        end

        if (!i_in.self_test) begin
            if (w_day_inc >= {1'b0, w_cfg.day_length_ticks}) begin
                n_day_ticks = 20'd0;
            end else begin
                n_day_ticks = w_day_inc[19:0];
            end
            n_sterilize_count = w_ster_cnt;
            n_making_count    = w_make_cnt;

            // Sequencer
            if (!i_in.uv_allowed) begin
                n_run_ticks  = 16'd0;
                n_seq_step   = 1'b0;
                n_run_active = 1'b0;
            end else if (!r_seq_step) begin
                // Arming: full edge, then tray at throw
                if (i_in.ice_full) begin
                    if (!r_full_seen) begin
                        n_full_seen = 1'b1;
                        n_arm_first = 1'b1;
                    end
                    if (i_in.tray_at_throw) begin
                        n_arm_second = n_arm_first;
                    end
                end else begin
                    n_full_seen  = 1'b0;
                    n_arm_first  = 1'b0;
                    n_arm_second = 1'b0;
                end
                w_go = n_arm_first & n_arm_second &
                       (w_ster_cnt < w_cfg.daily_sterilize_limit);

                if (w_go) begin
                    n_arm_first  = 1'b0;
                    n_arm_second = 1'b0;
                    n_seq_step   = 1'b1;
                    n_run_active = 1'b1;
                    n_run_ticks  = 16'd0;
                    if (w_ster_inc >= {1'b0, w_cfg.daily_sterilize_limit}) begin
                        n_sterilize_count = w_cfg.daily_sterilize_limit;
                    end else begin
                        n_sterilize_count = w_ster_inc[7:0];
                    end
                end else if (i_in.making_phase) begin
                    // Making phase lamp use
                    if (!r_phase_seen) begin
                        n_phase_seen = 1'b1;
                        if (w_make_inc >= {1'b0, w_cfg.making_count_limit}) begin
                            n_making_count  = w_cfg.making_count_limit;
                            n_making_enable = 1'b0;
                        end else begin
                            n_making_count  = w_make_inc[7:0];
                            n_making_enable = 1'b1;
                        end
                    end
                    if (!w_paused && n_making_enable) begin
                        if (w_make_ticks_inc >= {1'b0, w_cfg.making_max_ticks}) begin
                            n_making_ticks = w_cfg.making_max_ticks;
                        end else begin
                            n_making_ticks = w_make_ticks_inc[19:0];
                            n_tray_req     = 1'b1;
                        end
                    end
                end else begin
                    n_making_ticks  = 20'd0;
                    n_phase_seen    = 1'b0;
                    n_making_enable = 1'b0;
                end
            end else if (r_run_active) begin
                // Timed run: cancel off throw, pause on off-reasons
                if (!i_in.tray_at_throw) begin
                    n_run_active = 1'b0;
                    n_run_ticks  = 16'd0;
                end else if (!w_paused) begin
                    if (w_run_inc >= {1'b0, w_cfg.sterilize_ticks}) begin
                        n_run_active = 1'b0;
                        n_run_ticks  = 16'd0;
                    end else begin
                        n_run_ticks = w_run_inc[15:0];
                    end
                    n_tray_req = 1'b1;
                end
            end else begin
                n_seq_step = 1'b0;
            end

            // Off-reasons for this tick
            n_cover_off_prev = ~i_in.cover_closed;
            if (i_in.extract_active) begin
                n_extract_off = 1'b1;
            end else if (!i_in.outlet_motor_moving) begin
                n_extract_off = 1'b0;
            end

            n_retry_pending = r_retry_pending | i_in.retry_request;
            if (n_retry_pending) begin
                if (w_retry_inc >= RETRY_HOLD_TICKS) begin
                    n_retry_pending = 1'b0;
                    n_retry_ticks   = 5'd0;
                end else begin
                    n_retry_ticks = w_retry_inc;
                    w_retry_off   = 1'b1;
                end
            end else begin
                n_retry_ticks = 5'd0;
            end

            n_forced    = n_cover_off_prev | n_extract_off | w_retry_off | i_in.lamp_error;
            n_lamp_last = ~n_forced & (n_tray_req | i_in.companion_on);
            n_lamp_on   = n_lamp_last;
        end
    end

    // State update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_ticks       <= 20'd0;
            r_sterilize_count <= 8'd0;
            r_making_count    <= 8'd0;
            r_seq_step        <= 1'b0;
            r_run_active      <= 1'b0;
            r_run_ticks       <= 16'd0;
            r_full_seen       <= 1'b0;
            r_arm_first       <= 1'b0;
            r_arm_second      <= 1'b0;
            r_phase_seen      <= 1'b0;
            r_making_enable   <= 1'b0;
            r_making_ticks    <= 20'd0;
            r_cover_off_prev  <= 1'b0;
            r_extract_off     <= 1'b0;
            r_retry_pending   <= 1'b0;
            r_retry_ticks     <= 5'd0;
            r_lamp_last       <= 1'b0;
        end else if (w_accept) begin
            r_day_ticks       <= n_day_ticks;
            r_sterilize_count <= n_sterilize_count;
            r_making_count    <= n_making_count;
            r_seq_step        <= n_seq_step;
            r_run_active      <= n_run_active;
            r_run_ticks       <= n_run_ticks;
            r_full_seen       <= n_full_seen;
            r_arm_first       <= n_arm_first;
            r_arm_second      <= n_arm_second;
            r_phase_seen      <= n_phase_seen;
            r_making_enable   <= n_making_enable;
            r_making_ticks    <= n_making_ticks;
            r_cover_off_prev  <= n_cover_off_prev;
            r_extract_off     <= n_extract_off;
            r_retry_pending   <= n_retry_pending;
            r_retry_ticks     <= n_retry_ticks;
            r_lamp_last       <= n_lamp_last;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lamp_on  <= n_lamp_on;
            r_tray_req <= n_tray_req;
            r_forced   <= n_forced;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.lamp_on         = r_lamp_on;
    assign o_out.tray_uv_request = r_tray_req;
    assign o_out.forced_off      = r_forced;

endmodule

// ----- design/ulss_cfg_regs.sv -----
// APB configuration register file for the sterilize sequencer.
// Depends on ulss_pkg for the register struct, indexes and reset values.
module ulss_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ulss_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ulss_pkg::t_cfg              o_cfg
);
    import ulss_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.day_length_ticks      <= DAY_LENGTH_RESET;
            r_cfg.sterilize_ticks       <= STERILIZE_RESET;
            r_cfg.daily_sterilize_limit <= DAILY_LIMIT_RESET;
            r_cfg.making_count_limit    <= MAKING_LIMIT_RESET;
            r_cfg.making_max_ticks      <= MAKING_MAX_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DAY_LENGTH:   r_cfg.day_length_ticks      <= pwdata[19:0];
                REG_STERILIZE:    r_cfg.sterilize_ticks       <= pwdata[15:0];
                REG_DAILY_LIMIT:  r_cfg.daily_sterilize_limit <= pwdata[7:0];
                REG_MAKING_LIMIT: r_cfg.making_count_limit    <= pwdata[7:0];
                REG_MAKING_MAX:   r_cfg.making_max_ticks      <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read-back mux, unused addresses read zero
    always_comb begin
        unique case (w_idx)
            REG_DAY_LENGTH:   prdata = {12'd0, r_cfg.day_length_ticks};
            REG_STERILIZE:    prdata = {16'd0, r_cfg.sterilize_ticks};
            REG_DAILY_LIMIT:  prdata = {24'd0, r_cfg.daily_sterilize_limit};
            REG_MAKING_LIMIT: prdata = {24'd0, r_cfg.making_count_limit};
            REG_MAKING_MAX:   prdata = {12'd0, r_cfg.making_max_ticks};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- dv/uv_lamp_sterilize_sequencer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for uv_lamp_sterilize_sequencer: directed ticks, then phases of
// random appliance ticks under changing limits, checked against a built-in lamp predictor.
// Depends on ulss_pkg, ulss_in_if, ulss_out_if and the sequencer RTL.
module uv_lamp_sterilize_sequencer_test;
    import ulss_pkg::*;

    // One tick request, field order matches the directed table columns
    typedef struct packed {
        logic self_test;
        logic uv_allowed;
        logic ice_full;
        logic tray_at_throw;
        logic making_phase;
        logic cover_closed;
        logic extract_active;
        logic outlet_motor_moving;
        logic retry_request;
        logic companion_on;
        logic lamp_error;
    } t_tick;

    typedef struct packed {
        logic lamp_on;
        logic tray_uv_request;
        logic forced_off;
    } t_lamp;

    typedef struct packed {
        t_tick stim;
        logic  fixed;
        t_lamp want;
    } t_plan_row;

    typedef enum {RX_FREE, RX_COIN, RX_ALTERNATE, RX_SPARSE} t_rx_mode;

    localparam int PHASES         = 8;
    localparam int TICKS_PER_PHASE = 225;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata, prdata;

    ulss_in_if  tick_ch ();
    ulss_out_if lamp_ch ();

    uv_lamp_sterilize_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (lamp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Predictor copy of the limits and sequencer state
    t_cfg        lim;
    logic [19:0] day_cnt;
    logic [7:0]  runs_today, phases_today;
    logic        in_run_step, run_live;
    logic [15:0] run_cnt;
    logic        full_latched, armed_full, armed_throw;
    logic        phase_counted, phase_lamp_ok;
    logic [19:0] phase_lamp_cnt;
    logic        cover_was_open, extract_hold, retry_hold;
    logic [4:0]  retry_cnt;
    logic        lamp_prev;

    t_lamp       lamp_due [$];
    int          n_bad = 0;
    int          n_checked = 0;
    int unsigned rx_hold_reqs = 0;
    t_tick       plant;

    // Directed ticks: st ua if tt mp cc ea om rr co le | fixed | lamp req forced
    t_plan_row tick_plan [22] = '{
        {11'b0_0_0_0_0_0_0_0_0_0_0, 1'b1, 3'b0_0_1},  // cover open after reset
        {11'b1_0_0_0_0_0_0_0_0_0_0, 1'b1, 3'b0_0_0},  // self test, lamp was off
        {11'b0_0_0_0_0_1_0_0_0_1_0, 1'b1, 3'b1_0_0},  // companion lights, not allowed
        {11'b1_1_1_1_1_1_1_1_1_1_1, 1'b1, 3'b1_0_0},  // self test holds lamp, retry ignored
        {11'b0_0_0_0_0_1_0_0_0_1_1, 1'b1, 3'b0_0_1},  // lamp error
        {11'b0_0_0_0_0_1_1_0_0_1_0, 1'b1, 3'b0_0_1},  // extraction latches off
        {11'b0_0_0_0_0_1_0_1_0_1_0, 1'b1, 3'b0_0_1},  // motor still moving keeps latch
        {11'b0_0_0_0_0_1_0_0_0_1_0, 1'b0, 3'b0_0_0},  // latch released
        {11'b0_1_0_0_1_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // making phase starts
        {11'b0_1_0_0_1_1_0_0_0_0_0, 1'b0, 3'b0_0_0},
        {11'b0_1_0_0_1_0_0_0_0_0_0, 1'b0, 3'b0_0_0},  // cover opens mid phase
        {11'b0_1_0_0_1_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // paused by last tick's cover
        {11'b0_1_0_0_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // phase ends
        {11'b0_1_1_0_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // ice full arms
        {11'b0_1_1_1_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // tray at throw, run starts
        {11'b0_1_1_1_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},
        {11'b0_1_1_1_0_1_1_0_0_0_0, 1'b0, 3'b0_0_0},  // extraction during run
        {11'b0_1_1_1_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // paused by extraction
        {11'b0_1_1_0_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // tray leaves, run cancelled
        {11'b0_1_1_0_0_1_0_0_0_0_0, 1'b0, 3'b0_0_0},  // back to standby
        {11'b0_1_1_1_1_1_1_1_1_1_1, 1'b0, 3'b0_0_0},  // every flag up but self test
        {11'b0_0_0_0_0_1_0_0_1_1_0, 1'b1, 3'b0_0_1}   // retry hold
    };

    function automatic void flag_bad(string msg);
        n_bad++;
        if (n_bad <= 10)
            $display("%s", msg);
    endfunction

    function automatic bit chance(int unsigned n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    // Lamp decision for one tick; advances the predictor state
    function automatic t_lamp sequence_tick(t_tick t);
        t_lamp       r;
        logic        req, retry_off, forced;
        int unsigned n;
        r = '0;
        req = 1'b0;
        retry_off = 1'b0;
        if (t.self_test) begin
            r.lamp_on = lamp_prev;
            return r;
        end

        // day rollover clears both daily counts
        n = day_cnt + 1;
        if (n >= lim.day_length_ticks) begin
            day_cnt = '0;
            runs_today = '0;
            phases_today = '0;
        end else begin
            day_cnt = n[19:0];
        end

        if (!t.uv_allowed) begin
            run_cnt = '0;
            in_run_step = 1'b0;
            run_live = 1'b0;
        end else if (!in_run_step) begin
            // arm on full edge, then tray at throw
            if (t.ice_full) begin
                if (!full_latched) begin
                    full_latched = 1'b1;
                    armed_full = 1'b1;
                end
                if (t.tray_at_throw)
                    armed_throw = armed_full;
            end else begin
                full_latched = 1'b0;
                armed_full = 1'b0;
                armed_throw = 1'b0;
            end
            if (armed_full && armed_throw && runs_today < lim.daily_sterilize_limit) begin
                armed_full = 1'b0;
                armed_throw = 1'b0;
                in_run_step = 1'b1;
                run_live = 1'b1;
                run_cnt = '0;
                n = runs_today + 1;
                runs_today = (n >= lim.daily_sterilize_limit) ? lim.daily_sterilize_limit
                                                               : n[7:0];
            end else if (t.making_phase) begin
                if (!phase_counted) begin
                    phase_counted = 1'b1;
                    n = phases_today + 1;
                    if (n >= lim.making_count_limit) begin
                        phases_today = lim.making_count_limit;
                        phase_lamp_ok = 1'b0;
                    end else begin
                        phases_today = n[7:0];
                        phase_lamp_ok = 1'b1;
                    end
                end
                if (!cover_was_open && !extract_hold && phase_lamp_ok) begin
                    n = phase_lamp_cnt + 1;
                    if (n >= lim.making_max_ticks) begin
                        phase_lamp_cnt = lim.making_max_ticks;
                    end else begin
                        phase_lamp_cnt = n[19:0];
                        req = 1'b1;
                    end
                end
            end else begin
                phase_lamp_cnt = '0;
                phase_counted = 1'b0;
                phase_lamp_ok = 1'b0;
            end
        end else if (run_live) begin
            if (!t.tray_at_throw) begin
                run_live = 1'b0;
                run_cnt = '0;
            end else if (!cover_was_open && !extract_hold) begin
                n = run_cnt + 1;
                if (n >= lim.sterilize_ticks) begin
                    run_live = 1'b0;
                    run_cnt = '0;
                end else begin
                    run_cnt = n[15:0];
                end
                req = 1'b1;
            end
        end else begin
            in_run_step = 1'b0;
        end

        // off reasons
        cover_was_open = !t.cover_closed;
        if (t.extract_active)
            extract_hold = 1'b1;
        else if (!t.outlet_motor_moving)
            extract_hold = 1'b0;
        if (t.retry_request)
            retry_hold = 1'b1;
        if (retry_hold) begin
            retry_cnt = retry_cnt + 1'b1;
            if (retry_cnt >= RETRY_HOLD_TICKS) begin
                retry_hold = 1'b0;
                retry_cnt = '0;
            end else begin
                retry_off = 1'b1;
            end
        end else begin
            retry_cnt = '0;
        end

        forced = cover_was_open | extract_hold | retry_off | t.lamp_error;
        lamp_prev = !forced && (req || t.companion_on);
        r.lamp_on = lamp_prev;
        r.tray_uv_request = req;
        r.forced_off = forced;
        return r;
    endfunction

    // Appliance-like tick: slowly changing levels plus short pulses, some pure noise
    function automatic t_tick next_random_tick();
        t_tick       t;
        logic [31:0] raw;
        if (chance(10)) begin
            raw = $urandom;
            t = raw[10:0];
            return t;
        end
        if (plant.uv_allowed ? chance(60) : chance(4))
            plant.uv_allowed = !plant.uv_allowed;
        if (chance(25))
            plant.ice_full = !plant.ice_full;
        if (chance(12))
            plant.tray_at_throw = !plant.tray_at_throw;
        if (chance(20))
            plant.making_phase = !plant.making_phase;
        if (plant.cover_closed ? chance(15) : chance(3))
            plant.cover_closed = !plant.cover_closed;
        if (chance(4))
            plant.outlet_motor_moving = !plant.outlet_motor_moving;
        if (chance(8))
            plant.companion_on = !plant.companion_on;
        t = plant;
        t.self_test = chance(30);
        t.extract_active = chance(30);
        t.retry_request = chance(100);
        t.lamp_error = chance(40);
        return t;
    endfunction

    task automatic put_tick(input t_tick t);
        tick_ch.self_test           <= t.self_test;
        tick_ch.uv_allowed          <= t.uv_allowed;
        tick_ch.ice_full            <= t.ice_full;
        tick_ch.tray_at_throw       <= t.tray_at_throw;
        tick_ch.making_phase        <= t.making_phase;
        tick_ch.cover_closed        <= t.cover_closed;
        tick_ch.extract_active      <= t.extract_active;
        tick_ch.outlet_motor_moving <= t.outlet_motor_moving;
        tick_ch.retry_request       <= t.retry_request;
        tick_ch.companion_on        <= t.companion_on;
        tick_ch.lamp_error          <= t.lamp_error;
    endtask

    // Offer one tick request until accepted, then queue its expected lamp result
    task automatic offer_tick(input t_tick t, input logic fixed, input t_lamp want);
        t_lamp calc;
        put_tick(t);
        tick_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!tick_ch.ready);
        calc = sequence_tick(t);
        lamp_due.push_back(fixed ? want : calc);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (lamp_due.size() != 0);
    endtask

    // APB write followed by a read back of the same register
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DAY_LENGTH:   lim.day_length_ticks = val[19:0];
            REG_STERILIZE:    lim.sterilize_ticks = val[15:0];
            REG_DAILY_LIMIT:  lim.daily_sterilize_limit = val[7:0];
            REG_MAKING_LIMIT: lim.making_count_limit = val[7:0];
            REG_MAKING_MAX:   lim.making_max_ticks = val[19:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== val)
            flag_bad($sformatf("register %s read back %h, wrote %h", idx.name(), prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [31:0] day, input logic [31:0] ster,
                               input logic [31:0] dlim, input logic [31:0] mlim,
                               input logic [31:0] mmax);
        write_reg(REG_DAY_LENGTH, day);
        write_reg(REG_STERILIZE, ster);
        write_reg(REG_DAILY_LIMIT, dlim);
        write_reg(REG_MAKING_LIMIT, mlim);
        write_reg(REG_MAKING_MAX, mmax);
    endtask

    // Stimulus: reset, directed table, then random phases
    initial begin : stim
        int burst_left;
        int gap;
        int hold_at;
        int drain_at;
        i_rst_n       <= 1'b0;
        tick_ch.valid <= 1'b0;
        put_tick('0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        lim = '{DAY_LENGTH_RESET, STERILIZE_RESET, DAILY_LIMIT_RESET,
                MAKING_LIMIT_RESET, MAKING_MAX_RESET};
        day_cnt = '0;
        runs_today = '0;
        phases_today = '0;
        in_run_step = 1'b0;
        run_live = 1'b0;
        run_cnt = '0;
        full_latched = 1'b0;
        armed_full = 1'b0;
        armed_throw = 1'b0;
        phase_counted = 1'b0;
        phase_lamp_ok = 1'b0;
        phase_lamp_cnt = '0;
        cover_was_open = 1'b0;
        extract_hold = 1'b0;
        retry_hold = 1'b0;
        retry_cnt = '0;
        lamp_prev = 1'b0;
        plant = '0;
        plant.uv_allowed = 1'b1;
        plant.cover_closed = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tick_plan[i])
            offer_tick(tick_plan[i].stim, tick_plan[i].fixed, tick_plan[i].want);
        wait_drained();

        burst_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: load_limits(1, 1, 0, 1, 1);
                2: load_limits(20'hFFFFF, 16'hFFFF, 255, 255, 20'hFFFFF);
                5: load_limits(20'hFFFFF, $urandom_range(1, 8), 255, 255,
                               $urandom_range(1, 12));
                6: load_limits($urandom_range(5, 15), $urandom_range(30, 60), 1, 2,
                               $urandom_range(3, 8));
                default: load_limits($urandom_range(30, 400), $urandom_range(1, 24),
                                     $urandom_range(0, 5), $urandom_range(1, 6),
                                     $urandom_range(1, 20));
            endcase
            hold_at  = $urandom_range(30, 120);
            drain_at = $urandom_range(140, 200);
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                // receiver long stall while requests keep coming
                if (k == hold_at)
                    rx_hold_reqs <= rx_hold_reqs + 1;
                if (k == drain_at)
                    wait_drained();
                // bursts and gaps; odd phases run back to back
                if (burst_left == 0) begin
                    gap = (p % 2 == 1) ? 0 : $urandom_range(0, 6);
                    if (gap > 0) begin
                        tick_ch.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
                offer_tick(next_random_tick(), 1'b0, '0);
            end
            wait_drained();
        end

        for (int w = 0; w < 2000 && lamp_due.size() != 0; w++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (lamp_due.size() != 0)
            flag_bad($sformatf("%0d lamp results never arrived", lamp_due.size()));
        if (n_bad == 0)
            $display("[uv_lamp_sterilize_sequencer] OK");
        else
            $display("[uv_lamp_sterilize_sequencer] ERROR");
        $finish;
    end

    // Receiver: changing stall patterns plus long holds on request
    initial begin : rx
        t_rx_mode    mode;
        int          mode_left;
        int          hold_left;
        int unsigned holds_done;
        mode = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        holds_done = 0;
        lamp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                lamp_ch.ready <= 1'b0;
            end else if (holds_done != rx_hold_reqs) begin
                holds_done++;
                hold_left = $urandom_range(120, 200);
                lamp_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                case (mode)
                    RX_FREE:      lamp_ch.ready <= 1'b1;
                    RX_COIN:      lamp_ch.ready <= $urandom_range(0, 3) != 0;
                    RX_ALTERNATE: lamp_ch.ready <= !lamp_ch.ready;
                    default:      lamp_ch.ready <= chance(4);
                endcase
            end
        end
    end

    // Compare each accepted lamp result with the oldest expectation
    always @(posedge i_clk) begin
        t_lamp got;
        t_lamp want;
        if (i_rst_n && lamp_ch.valid && lamp_ch.ready) begin
            got = {lamp_ch.lamp_on, lamp_ch.tray_uv_request, lamp_ch.forced_off};
            if (lamp_due.size() == 0) begin
                flag_bad($sformatf("unexpected lamp result %b", got));
            end else begin
                want = lamp_due.pop_front();
                if (got.lamp_on !== want.lamp_on
                        || got.tray_uv_request !== want.tray_uv_request
                        || got.forced_off !== want.forced_off)
                    flag_bad($sformatf({"result %0d: lamp_on/tray_uv_request/forced_off ",
                                        "expected %b%b%b got %b%b%b"}, n_checked,
                                       want.lamp_on, want.tray_uv_request, want.forced_off,
                                       got.lamp_on, got.tray_uv_request, got.forced_off));
            end
            n_checked++;
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("[uv_lamp_sterilize_sequencer] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ulss_pkg.sv
design/ulss_in_if.sv
design/ulss_out_if.sv
design/ulss_cfg_regs.sv
design/uv_lamp_sterilize_sequencer.sv
dv/uv_lamp_sterilize_sequencer_test.sv
